@@ rtl/utf_codepoint_transcoder_top_macros.svh @@
// Assertion helpers for the transcoder
`ifndef UTF_CODEPOINT_TRANSCODER_TOP_MACROS_SVH
`define UTF_CODEPOINT_TRANSCODER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define UTFCT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utfct: same-cycle check failed");

// delayed implication, checked outside reset
`define UTFCT_ASSERT_LAT2(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("utfct: latency check failed");

`endif

@@ rtl/utfct_pkg.sv @@
package utfct_pkg;

  // operation codes
  localparam logic [2:0] OP_U8TO32  = 3'd0;
  localparam logic [2:0] OP_U32TO8  = 3'd1;
  localparam logic [2:0] OP_U16TO32 = 3'd2;
  localparam logic [2:0] OP_U32TO16 = 3'd3;
  localparam logic [2:0] OP_U8TO16  = 3'd4;
  localparam logic [2:0] OP_U16TO8  = 3'd5;

  // target encodings
  localparam logic [1:0] FMT_U32 = 2'd0;
  localparam logic [1:0] FMT_U8  = 2'd1;
  localparam logic [1:0] FMT_U16 = 2'd2;

  localparam logic [20:0] CP_MAX = 21'h10FFFF;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] code_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] code_out;
    logic [2:0]  unit_count;
    logic        conv_error;
  } out_item_t;

  // classified item: decoded code point and target encoding
  typedef struct packed {
    logic        ok;
    logic [1:0]  fmt;
    logic [20:0] cp;
  } cls_item_t;

  // queue status toward the front end
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

@@ rtl/utfct_front.sv @@
module utfct_front (
  input  utfct_pkg::in_item_t  item,
  output utfct_pkg::cls_item_t cls
);
  import utfct_pkg::*;

  logic [31:0] w;
  logic [1:0]  pos;
  logic [7:0]  lead;
  logic [2:0]  len8;
  logic        lead_ok;
  logic [20:0] cp8;
  logic        ok8;
  logic [15:0] hi16;
  logic [15:0] lo16;
  logic [20:0] cp16;
  logic        ok16;
  logic        ok32;

  assign w    = item.code_in;
  assign hi16 = w[31:16];
  assign lo16 = w[15:0];

  // UTF-8: lead byte is the highest nonzero byte
  always_comb begin
    if (w[31:24] != 8'h00)      pos = 2'd3;
    else if (w[23:16] != 8'h00) pos = 2'd2;
    else if (w[15:8] != 8'h00)  pos = 2'd1;
    else                        pos = 2'd0;
    lead = w[8*pos +: 8];
  end

  always_comb begin
    lead_ok = 1'b1;
    len8    = 3'd1;
    case (lead) inside
      [8'h00:8'h7F]: len8 = 3'd1;
      [8'hC2:8'hDF]: len8 = 3'd2;
      [8'hE0:8'hEF]: len8 = 3'd3;
      [8'hF0:8'hF7]: len8 = 3'd4;
      default:       lead_ok = 1'b0;
    endcase
  end

  always_comb begin
    case (pos)
      2'd0:    cp8 = {13'd0, lead};
      2'd1:    cp8 = {10'd0, lead[4:0], w[5:0]};
      2'd2:    cp8 = {5'd0, lead[3:0], w[13:8], w[5:0]};
      default: cp8 = {lead[2:0], w[21:16], w[13:8], w[5:0]};
    endcase
    ok8 = lead_ok && (len8 == ({1'b0, pos} + 3'd1)) && (cp8 <= CP_MAX) &&
          !(cp8[20:11] == 10'b00000_11011);
  end

  // UTF-16: one unit or a high/low surrogate pair
  always_comb begin
    if (hi16 == 16'h0000) begin
      ok16 = !(lo16 inside {[16'hD800:16'hDFFF]});
      cp16 = {5'd0, lo16};
    end else begin
      ok16 = (hi16 inside {[16'hD800:16'hDBFF]}) && (lo16 inside {[16'hDC00:16'hDFFF]});
      cp16 = {1'b0, hi16[9:0], lo16[9:0]} + 21'h10000;
    end
  end

  // UTF-32: range and surrogate check
  assign ok32 = (w <= {11'd0, CP_MAX}) && !(w[20:11] == 10'b00000_11011);

  // classify by operation
  always_comb begin
    cls.ok  = 1'b0;
    cls.fmt = FMT_U32;
    cls.cp  = w[20:0];
    case (item.operation)
      OP_U8TO32: begin
        cls.ok = ok8; cls.fmt = FMT_U32; cls.cp = cp8;
      end
      OP_U8TO16: begin
        cls.ok = ok8; cls.fmt = FMT_U16; cls.cp = cp8;
      end
      OP_U16TO32: begin
        cls.ok = ok16; cls.fmt = FMT_U32; cls.cp = cp16;
      end
      OP_U16TO8: begin
        cls.ok = ok16; cls.fmt = FMT_U8; cls.cp = cp16;
      end
      OP_U32TO8: begin
        cls.ok = ok32; cls.fmt = FMT_U8;
      end
      OP_U32TO16: begin
        cls.ok = ok32; cls.fmt = FMT_U16;
      end
      default: cls.ok = 1'b0;
    endcase
  end

endmodule

@@ rtl/utfct_queue.sv @@
module utfct_queue #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  utfct_pkg::cls_item_t push_data,
  input  logic                 pop,
  output utfct_pkg::cls_item_t head,
  output utfct_pkg::q_stat_t   stat
);
  import utfct_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  cls_item_t       ent_r   [DEPTH];
  cls_item_t       ent_nxt [DEPTH];
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   cnt_nxt;
  logic [CW-1:0]   wr_idx;
  logic            do_pop;
  logic            do_push;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign head       = ent_r[0];
  assign do_pop     = pop && !stat.empty;
  assign do_push    = push && !stat.full;
  assign wr_idx     = cnt_r - CW'(do_pop);

  // shift toward the head on pop, then drop the new beat at the tail
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (do_pop && (i + 1 < DEPTH)) ent_nxt[i] = ent_r[(i + 1) % DEPTH];
      else                           ent_nxt[i] = ent_r[i];
      if (do_push && (CW'(i) == wr_idx)) ent_nxt[i] = push_data;
    end
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) ent_r[i] <= ent_nxt[i];
  end

endmodule

@@ rtl/utfct_back.sv @@
module utfct_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  utfct_pkg::cls_item_t cls,
  output logic                 out_valid,
  output utfct_pkg::out_item_t out_data
);
  import utfct_pkg::*;

  logic        valid_r;
  out_item_t   res_r;
  out_item_t   res_nxt;
  logic [20:0] cp;
  logic [19:0] off;

  assign cp  = cls.cp;
  assign off = 20'(cp - 21'h10000);

  // encode the code point in the target format
  always_comb begin
    res_nxt.code_out   = '0;
    res_nxt.unit_count = 3'd0;
    res_nxt.conv_error = 1'b1;
    if (cls.ok) begin
      res_nxt.conv_error = 1'b0;
      case (cls.fmt)
        FMT_U32: begin
          res_nxt.code_out   = {11'd0, cp};
          res_nxt.unit_count = 3'd1;
        end
        FMT_U8: begin
          if (cp < 21'h80) begin
            res_nxt.code_out   = {11'd0, cp};
            res_nxt.unit_count = 3'd1;
          end else if (cp < 21'h800) begin
            res_nxt.code_out   = {16'd0, 3'b110, cp[10:6], 2'b10, cp[5:0]};
            res_nxt.unit_count = 3'd2;
          end else if (cp < 21'h10000) begin
            res_nxt.code_out   = {8'd0, 4'b1110, cp[15:12], 2'b10, cp[11:6],
                                  2'b10, cp[5:0]};
            res_nxt.unit_count = 3'd3;
          end else begin
            res_nxt.code_out   = {5'b11110, cp[20:18], 2'b10, cp[17:12],
                                  2'b10, cp[11:6], 2'b10, cp[5:0]};
            res_nxt.unit_count = 3'd4;
          end
        end
        FMT_U16: begin
          if (cp < 21'h10000) begin
            res_nxt.code_out   = {11'd0, cp};
            res_nxt.unit_count = 3'd1;
          end else begin
            res_nxt.code_out   = {6'b110110, off[19:10], 6'b110111, off[9:0]};
            res_nxt.unit_count = 3'd2;
          end
        end
        default: begin
          res_nxt.conv_error = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = res_r;

endmodule

@@ rtl/utf_codepoint_transcoder_top.sv @@
// UTF-8 / UTF-16 / UTF-32 single-character transcoder.
// Input: drive in_data (operation, code_in packed right-aligned) with start high;
//   the beat is taken at a rising edge where start is high and busy is low.
// Output: out_valid strobes for exactly one cycle with out_data (code_out,
//   unit_count, conv_error); the receiver must take it in that cycle.
// Structure: the front end decodes and checks the source into a code point,
//   a small queue holds classified beats, the back end encodes and registers.
// Path: an accepted beat is written into the queue, and the back end registers
//   its encoded result from the queue head; out_valid is registered alongside it.
// Throughput: one character per cycle; the back end drains one queue entry
//   every cycle, so the queue never fills and busy stays low in use.
// Busy rises only if the queue is full (QUEUE_DEPTH entries).
// Reset (synchronous, rst_n low) empties the queue and drops the output strobe;
//   no beat in flight survives it.
// Errors give code_out 0, unit_count 0 and conv_error 1.
module utf_codepoint_transcoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  utfct_pkg::in_item_t  in_data,
  output logic                 out_valid,
  output utfct_pkg::out_item_t out_data
);
  import utfct_pkg::*;

  `include "utf_codepoint_transcoder_top_macros.svh"

  cls_item_t cls;
  cls_item_t head;
  q_stat_t   qstat;
  logic      accept;

  assign busy   = qstat.full;
  assign accept = start && !qstat.full;

  // decode and classify
  utfct_front u_front (
    .item (in_data),
    .cls  (cls)
  );

  // decoupling queue
  utfct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (cls),
    .pop       (!qstat.empty),
    .head      (head),
    .stat      (qstat)
  );

  // encode and register
  utfct_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (!qstat.empty),
    .cls       (head),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // checks
  `UTFCT_ASSERT_SAME(a_err_zero, out_valid && out_data.conv_error,
                     out_data.code_out == 32'd0 && out_data.unit_count == 3'd0)
  `UTFCT_ASSERT_SAME(a_ok_count, out_valid && !out_data.conv_error,
                     out_data.unit_count != 3'd0 && out_data.unit_count <= 3'd4)
  `UTFCT_ASSERT_LAT2(a_latency, start && !busy, out_valid)

endmodule

@@ test/tb_utf_codepoint_transcoder_top.sv @@
`timescale 1ns / 1ps

module tb_utf_codepoint_transcoder_top;
  import utfct_pkg::*;

  // operation codes the block does not define
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  // directed rows: expected result typed in, or left to the predictor
  localparam bit TYPED   = 1'b1;
  localparam bit PREDICT = 1'b0;

  localparam out_item_t CONV_FAIL = {32'd0, 3'd0, 1'b1};

  localparam int RANDOM_CHARS = 1200;
  localparam int DRAIN_LIMIT  = 200;
  localparam int TAIL_CYCLES  = 4;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  out_item_t due_conversions[$];
  dir_row_t  dir_rows[$];
  int        fail_count = 0;
  int        beat_count = 0;
  bit        burst_mode = 1'b0;

  utf_codepoint_transcoder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // character conversion predictor
  // ---------------------------------------------------------------------

  function automatic bit cp_ok(input logic [31:0] cp);
    return (cp <= 32'(CP_MAX)) && !(cp >= 32'hD800 && cp <= 32'hDFFF);
  endfunction

  function automatic bit decode_u8(input logic [31:0] w, output logic [31:0] cp);
    int         pos;
    int         len;
    logic [7:0] lead;
    logic [31:0] v;
    cp = 32'd0;
    if (w[31:24] != 8'd0) pos = 3;
    else if (w[23:16] != 8'd0) pos = 2;
    else if (w[15:8] != 8'd0) pos = 1;
    else pos = 0;
    lead = w[8*pos +: 8];
    // lead byte sets the length; C0, C1, lone continuations and F8+ are bad
    if (lead < 8'h80) len = 1;
    else if (lead >= 8'hC2 && lead <= 8'hDF) len = 2;
    else if (lead >= 8'hE0 && lead <= 8'hEF) len = 3;
    else if (lead >= 8'hF0 && lead <= 8'hF7) len = 4;
    else return 1'b0;
    if (len != pos + 1) return 1'b0;
    case (len)
      1: v = {24'd0, lead};
      2: v = {27'd0, lead[4:0]};
      3: v = {28'd0, lead[3:0]};
      default: v = {29'd0, lead[2:0]};
    endcase
    // continuation bytes contribute six bits each, unchecked
    for (int i = 1; i < len; i++) v = (v << 6) | {26'd0, w[8*(pos-i) +: 6]};
    if (!cp_ok(v)) return 1'b0;
    cp = v;
    return 1'b1;
  endfunction

  function automatic bit decode_u16(input logic [31:0] w, output logic [31:0] cp);
    logic [15:0] hi;
    logic [15:0] lo;
    hi = w[31:16];
    lo = w[15:0];
    cp = 32'd0;
    // single unit: must not be a surrogate
    if (hi == 16'd0) begin
      if (lo >= 16'hD800 && lo <= 16'hDFFF) return 1'b0;
      cp = {16'd0, lo};
      return 1'b1;
    end
    // pair: high surrogate over low surrogate
    if (hi >= 16'hD800 && hi <= 16'hDBFF && lo >= 16'hDC00 && lo <= 16'hDFFF) begin
      cp = {12'd0, hi[9:0], lo[9:0]} + 32'h10000;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [31:0] encode_u8(input logic [31:0] cp, output logic [2:0] n);
    if (cp < 32'h80) begin
      n = 3'd1;
      return cp;
    end
    if (cp < 32'h800) begin
      n = 3'd2;
      return {16'd0, 3'b110, cp[10:6], 2'b10, cp[5:0]};
    end
    if (cp < 32'h10000) begin
      n = 3'd3;
      return {8'd0, 4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
    end
    n = 3'd4;
    return {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
  endfunction

  function automatic logic [31:0] encode_u16(input logic [31:0] cp, output logic [2:0] n);
    logic [31:0] off;
    if (cp < 32'h10000) begin
      n = 3'd1;
      return cp;
    end
    off = cp - 32'h10000;
    n = 3'd2;
    return {6'b110110, off[19:10], 6'b110111, off[9:0]};
  endfunction

  function automatic out_item_t transcode_char(input in_item_t it);
    logic [31:0] cp;
    logic [31:0] word;
    logic [2:0]  n;
    bit          ok;
    out_item_t   r;
    cp   = 32'd0;
    word = 32'd0;
    n    = 3'd0;
    case (it.operation)
      OP_U8TO32, OP_U8TO16:   ok = decode_u8(it.code_in, cp);
      OP_U16TO32, OP_U16TO8:  ok = decode_u16(it.code_in, cp);
      OP_U32TO8, OP_U32TO16: begin
        cp = it.code_in;
        ok = cp_ok(cp);
      end
      default:                ok = 1'b0;
    endcase
    if (ok) begin
      case (it.operation)
        OP_U8TO32, OP_U16TO32: begin
          word = cp;
          n    = 3'd1;
        end
        OP_U32TO8, OP_U16TO8:  word = encode_u8(cp, n);
        default:               word = encode_u16(cp, n);
      endcase
    end
    r.code_out   = ok ? word : 32'd0;
    r.unit_count = ok ? n : 3'd0;
    r.conv_error = !ok;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus generation
  // ---------------------------------------------------------------------

  // valid code point, weighted over the encoding length classes
  function automatic logic [31:0] random_cp();
    logic [31:0] cp;
    case ($urandom_range(0, 5))
      0: cp = $urandom_range(0, 32'h7F);
      1: cp = $urandom_range(32'h80, 32'h7FF);
      2: cp = $urandom_range(32'h800, 32'hFFFF);
      3: cp = $urandom_range(32'h10000, 32'h10FFFF);
      4: begin
        case ($urandom_range(0, 9))
          0: cp = 32'h0;
          1: cp = 32'h7F;
          2: cp = 32'h80;
          3: cp = 32'h7FF;
          4: cp = 32'h800;
          5: cp = 32'hD7FF;
          6: cp = 32'hE000;
          7: cp = 32'hFFFF;
          8: cp = 32'h10000;
          default: cp = 32'h10FFFF;
        endcase
      end
      default: cp = $urandom_range(0, 32'h10FFFF);
    endcase
    // move surrogates out into E800-EFFF
    if (cp >= 32'hD800 && cp <= 32'hDFFF) cp = cp ^ 32'h3000;
    return cp;
  endfunction

  function automatic logic [31:0] source_word(input logic [2:0] op, input logic [31:0] cp);
    logic [2:0] n;
    case (op)
      OP_U8TO32, OP_U8TO16:  return encode_u8(cp, n);
      OP_U16TO32, OP_U16TO8: return encode_u16(cp, n);
      default:               return cp;
    endcase
  endfunction

  function automatic in_item_t random_char();
    in_item_t    it;
    logic [31:0] cp;
    logic [31:0] w;
    logic [2:0]  n;
    logic [7:0]  lead;
    logic [15:0] hi;
    logic [15:0] lo;
    int          kind;
    int          nb;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      // well-formed character in any source format
      it.operation = 3'($urandom_range(0, 5));
      it.code_in   = source_word(it.operation, random_cp());
    end else if (kind < 78) begin
      // malformed UTF-8
      it.operation = $urandom_range(0, 1) ? OP_U8TO16 : OP_U8TO32;
      case ($urandom_range(0, 3))
        0: begin
          case ($urandom_range(0, 2))
            0: lead = 8'hC0 | 8'($urandom_range(0, 1));
            1: lead = 8'h80 | 8'($urandom_range(0, 63));
            default: lead = 8'hF8 | 8'($urandom_range(0, 7));
          endcase
          nb = $urandom_range(0, 3);
          it.code_in = ({24'd0, lead} << (8 * nb)) | ($urandom & ((32'h1 << (8 * nb)) - 1));
        end
        1: begin
          // byte count disagrees with the lead
          w = encode_u8(random_cp(), n);
          if (n < 3'd4 && $urandom_range(0, 1)) w = (w << 8) | 32'($urandom_range(0, 255));
          else w = w >> 8;
          it.code_in = w;
        end
        2: begin
          cp = $urandom_range(32'hD800, 32'hDFFF);
          it.code_in = {8'd0, 4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
        end
        default: begin
          cp = $urandom_range(32'h110000, 32'h1FFFFF);
          it.code_in = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                        2'b10, cp[5:0]};
        end
      endcase
    end else if (kind < 84) begin
      // malformed UTF-16
      it.operation = $urandom_range(0, 1) ? OP_U16TO8 : OP_U16TO32;
      case ($urandom_range(0, 3))
        0: begin
          hi = 16'd0;
          lo = 16'($urandom_range(32'hD800, 32'hDFFF));
        end
        1: begin
          hi = 16'($urandom_range(32'hD800, 32'hDBFF));
          lo = 16'($urandom);
        end
        2: begin
          hi = 16'($urandom_range(32'hDC00, 32'hDFFF));
          lo = 16'($urandom_range(32'hD800, 32'hDBFF));
        end
        default: begin
          hi = 16'($urandom_range(1, 32'hFFFF));
          lo = 16'($urandom_range(32'hDC00, 32'hDFFF));
        end
      endcase
      it.code_in = {hi, lo};
    end else if (kind < 88) begin
      // UTF-32 surrogate or beyond the last code point
      it.operation = $urandom_range(0, 1) ? OP_U32TO16 : OP_U32TO8;
      it.code_in   = $urandom_range(0, 1) ? $urandom_range(32'hD800, 32'hDFFF)
                                          : $urandom_range(32'h110000, 32'hFFFFFFFF);
    end else begin
      // noise, reserved operations included
      it.operation = 3'($urandom_range(0, 7));
      it.code_in   = $urandom_range(0, 1) ? $urandom : ($urandom >> $urandom_range(0, 31));
    end
    return it;
  endfunction

  task automatic add_row(input logic [2:0] op, input logic [31:0] code, input bit typed,
                         input out_item_t want);
    dir_row_t row;
    row.stim.operation = op;
    row.stim.code_in   = code;
    row.typed          = typed;
    row.want           = want;
    dir_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------
  // driver: one beat per call, called at a falling edge
  // ---------------------------------------------------------------------

  task automatic drive_char(input in_item_t it, input bit typed, input out_item_t want);
    int gap;
    if (beat_count % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
    beat_count++;
    gap = burst_mode ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start   <= 1'b0;
      in_data <= {3'($urandom), $urandom};
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    due_conversions.push_back(typed ? want : transcode_char(it));
    @(negedge clk);
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (due_conversions.size() == 0) begin
        note_failure($sformatf("unexpected result beat: code_out=%h units=%0d err=%0b",
                               out_data.code_out, out_data.unit_count, out_data.conv_error));
      end else begin
        want = due_conversions.pop_front();
        if (out_data.code_out !== want.code_out)
          note_failure($sformatf("code_out mismatch: expected %h, got %h",
                                 want.code_out, out_data.code_out));
        if (out_data.unit_count !== want.unit_count)
          note_failure($sformatf("unit_count mismatch: expected %0d, got %0d",
                                 want.unit_count, out_data.unit_count));
        if (out_data.conv_error !== want.conv_error)
          note_failure($sformatf("conv_error mismatch: expected %0b, got %0b",
                                 want.conv_error, out_data.conv_error));
      end
    end
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------

  initial begin
    int waited;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;

    // directed rows: extremes, every operation, each error class
    add_row(OP_U8TO32,  32'h0000_0000, TYPED,   {32'h0, 3'd1, 1'b0});
    add_row(OP_U8TO32,  32'h0000_007F, TYPED,   {32'h7F, 3'd1, 1'b0});
    add_row(OP_U8TO32,  32'hF48F_BFBF, TYPED,   {32'h10FFFF, 3'd1, 1'b0});
    add_row(OP_U8TO32,  32'h0000_C0AF, TYPED,   CONV_FAIL);
    add_row(OP_U8TO32,  32'h0000_C1BF, TYPED,   CONV_FAIL);
    add_row(OP_U8TO32,  32'h0000_0080, TYPED,   CONV_FAIL);
    add_row(OP_U8TO32,  32'hF880_8080, TYPED,   CONV_FAIL);
    add_row(OP_U8TO32,  32'hFFFF_FFFF, TYPED,   CONV_FAIL);
    add_row(OP_U8TO16,  32'h0000_41C3, TYPED,   CONV_FAIL);
    add_row(OP_U8TO16,  32'h0000_00C3, TYPED,   CONV_FAIL);
    add_row(OP_U8TO16,  32'h00ED_A080, TYPED,   CONV_FAIL);
    add_row(OP_U8TO16,  32'hF490_8080, TYPED,   CONV_FAIL);
    add_row(OP_U8TO16,  32'h00E0_8080, PREDICT, '0);
    add_row(OP_U8TO16,  32'hF090_8D88, PREDICT, '0);
    add_row(OP_U32TO8,  32'h0000_0000, TYPED,   {32'h0, 3'd1, 1'b0});
    add_row(OP_U32TO8,  32'h0010_FFFF, PREDICT, '0);
    add_row(OP_U32TO8,  32'h0000_DFFF, TYPED,   CONV_FAIL);
    add_row(OP_U32TO8,  32'hFFFF_FFFF, TYPED,   CONV_FAIL);
    add_row(OP_U32TO16, 32'h0000_D800, TYPED,   CONV_FAIL);
    add_row(OP_U32TO16, 32'h0011_0000, TYPED,   CONV_FAIL);
    add_row(OP_U32TO16, 32'h0001_0000, TYPED,   {32'hD800DC00, 3'd2, 1'b0});
    add_row(OP_U32TO16, 32'h0010_FFFF, TYPED,   {32'hDBFFDFFF, 3'd2, 1'b0});
    add_row(OP_U16TO32, 32'hDBFF_DFFF, TYPED,   {32'h10FFFF, 3'd1, 1'b0});
    add_row(OP_U16TO32, 32'h0000_D800, TYPED,   CONV_FAIL);
    add_row(OP_U16TO32, 32'hD800_DBFF, TYPED,   CONV_FAIL);
    add_row(OP_U16TO32, 32'h0001_DC41, TYPED,   CONV_FAIL);
    add_row(OP_U16TO8,  32'hD83D_DE00, PREDICT, '0);
    add_row(OP_U16TO8,  32'h0000_FFFF, PREDICT, '0);
    add_row(OP_RSVD_6,  32'h0000_0041, TYPED,   CONV_FAIL);
    add_row(OP_RSVD_7,  32'hFFFF_FFFF, TYPED,   CONV_FAIL);

    // hold synchronous reset, then release it at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) drive_char(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

    for (int i = 0; i < RANDOM_CHARS; i++) drive_char(random_char(), PREDICT, '0);

    start <= 1'b0;

    // drain outstanding results
    waited = 0;
    while (due_conversions.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (due_conversions.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", due_conversions.size()));
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_utf_codepoint_transcoder_top passed");
    end else begin
      $display("tb_utf_codepoint_transcoder_top failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("tb_utf_codepoint_transcoder_top failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/utfct_pkg.sv
rtl/utfct_front.sv
rtl/utfct_queue.sv
rtl/utfct_back.sv
rtl/utf_codepoint_transcoder_top.sv
test/tb_utf_codepoint_transcoder_top.sv
